// ----- src/hidkbd_pkg.sv -----
// Shared constants, types and the usage translation table for the keyboard decoder.
`default_nettype none
package hidkbd_pkg;

  localparam int KEY_SLOTS      = 6;
  localparam int NUM_MODS       = 6;
  localparam int NUM_CAND       = NUM_MODS + 2 * KEY_SLOTS;
  localparam int CAND_W         = $clog2(NUM_CAND);
  localparam int SLOT_W         = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam int MOD_W          = $clog2(NUM_MODS);
  localparam logic [6:0] MIN_REPORT_LEN = 7'd8;

  localparam logic [7:0] MOD_BITS [NUM_MODS] = '{8'h01, 8'h02, 8'h04, 8'h10, 8'h20, 8'h40};
  localparam logic [7:0] MOD_CODES [NUM_MODS] = '{8'h9D, 8'hB6, 8'hB8, 8'h9D, 8'hB6, 8'hB8};

  localparam logic EV_DOWN = 1'b0;
  localparam logic EV_UP   = 1'b1;

  typedef logic [7:0] usage_t;
  typedef usage_t slots_t [KEY_SLOTS];

  typedef struct packed {
    logic       hit;
    logic [7:0] code;
    logic [6:0] ascii;
  } xlat_t;

  function automatic xlat_t translate(input usage_t u);
    xlat_t r;
    logic [7:0] c;
    r = '0;
    c = 8'h00;
    case (u) inside
      [8'h04:8'h1D]: begin
        c = 8'h61 + (u - 8'h04);
        r = '{1'b1, c, c[6:0]};
      end
      [8'h1E:8'h26]: begin
        c = 8'h31 + (u - 8'h1E);
        r = '{1'b1, c, c[6:0]};
      end
      8'h27: r = '{1'b1, 8'h30, 7'h30};
      [8'h3A:8'h43]: begin
        c = 8'hBB + (u - 8'h3A);
        r = '{1'b1, c, 7'h00};
      end
      8'h28: r = '{1'b1, 8'd13, 7'h00};
      8'h29: r = '{1'b1, 8'd27, 7'h00};
      8'h2A: r = '{1'b1, 8'h7F, 7'h00};
      8'h2B: r = '{1'b1, 8'd9, 7'h00};
      8'h2C: r = '{1'b1, 8'h20, 7'h20};
      8'h36: r = '{1'b1, 8'h2C, 7'h2C};
      8'h37: r = '{1'b1, 8'h2E, 7'h2E};
      8'h4F: r = '{1'b1, 8'hAE, 7'h00};
      8'h50: r = '{1'b1, 8'hAC, 7'h00};
      8'h51: r = '{1'b1, 8'hAF, 7'h00};
      8'h52: r = '{1'b1, 8'hAD, 7'h00};
      8'h44: r = '{1'b1, 8'hD7, 7'h00};
      8'h45: r = '{1'b1, 8'hD8, 7'h00};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- src/hid_keyboard_report_to_key_events.sv -----
// Top level: boot keyboard report to key press/release transaction stream.
//
// Input channel (in_*): one transaction carries one boot keyboard report:
// byte count, modifier byte and six key usage slots. Reports shorter than
// eight bytes are taken and dropped without touching the stored state.
// Output channel (out_*): one transaction per key event: kind (press or
// release), translated key code, ASCII on printable presses, and a last
// flag on the final event of a report. A report with no change gives none.
// Timing: a report is scanned over 18 candidate events (six modifier bits,
// six new-key checks, six released-key checks), one per cycle while the
// scan is not paused by a stall, through a single shared compare/translate
// unit, plus a flush state. in_stall stays high while the scan and flush
// run, so no new report is taken until the last one is through. An event is
// held in a pending register so the last flag is known when it moves into
// the output register; it moves when the next event is found or at the
// flush.
// Stall: when out_stall holds the output register full, the scan pauses
// on the next event found; nothing is dropped.
// Reset (synchronous, rst_n low): stored modifiers and keys clear to zero,
// output and scan go idle.
`default_nettype none
module hid_keyboard_report_to_key_events (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output      logic       in_stall,
  input  wire logic [6:0] in_report_length,
  input  wire logic [7:0] in_modifier_byte,
  input  wire logic [7:0] in_key_slot_0,
  input  wire logic [7:0] in_key_slot_1,
  input  wire logic [7:0] in_key_slot_2,
  input  wire logic [7:0] in_key_slot_3,
  input  wire logic [7:0] in_key_slot_4,
  input  wire logic [7:0] in_key_slot_5,
  output      logic       out_valid,
  input  wire logic       out_stall,
  output      logic       out_event_kind,
  output      logic [7:0] out_key_code,
  output      logic [6:0] out_ascii_code,
  output      logic       out_last
);
  import hidkbd_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FLUSH} state_t;

  state_t state_r, state_nxt;
  logic [CAND_W-1:0] idx_r, idx_nxt;
  logic [7:0] mods_r, mods_nxt;
  logic [7:0] prior_mods_r, prior_mods_nxt;
  slots_t cur_r, cur_nxt;
  slots_t prior_keys_r, prior_keys_nxt;

  logic       pend_valid_r, pend_valid_nxt;
  logic       pend_kind_r, pend_kind_nxt;
  logic [7:0] pend_code_r, pend_code_nxt;
  logic [6:0] pend_ascii_r, pend_ascii_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic       out_kind_r, out_kind_nxt;
  logic [7:0] out_code_r, out_code_nxt;
  logic [6:0] out_ascii_r, out_ascii_nxt;
  logic       out_last_r, out_last_nxt;

  slots_t in_slots;
  assign in_slots = '{in_key_slot_0, in_key_slot_1, in_key_slot_2,
                      in_key_slot_3, in_key_slot_4, in_key_slot_5};

  // Shared candidate unit: pick one usage and one list, search, translate.
  logic              is_mod, is_down;
  logic [MOD_W-1:0]  mod_sel;
  logic [CAND_W-1:0] key_off;
  logic [SLOT_W-1:0] slot_sel;
  usage_t            u_sel;
  logic              found;
  xlat_t             xl;
  logic              now_b, was_b;
  logic              cand_emit, cand_kind;
  logic [7:0]        cand_code;
  logic [6:0]        cand_ascii;

  always_comb begin
    is_mod  = idx_r < CAND_W'(NUM_MODS);
    is_down = idx_r < CAND_W'(NUM_MODS + KEY_SLOTS);
    mod_sel = idx_r[MOD_W-1:0];
    key_off = is_down ? (idx_r - CAND_W'(NUM_MODS))
                      : (idx_r - CAND_W'(NUM_MODS + KEY_SLOTS));
    slot_sel = key_off[SLOT_W-1:0];
    u_sel = is_down ? cur_r[slot_sel] : prior_keys_r[slot_sel];
    found = 1'b0;
    for (int j = 0; j < KEY_SLOTS; j++) begin
      if ((is_down ? prior_keys_r[j] : cur_r[j]) == u_sel) found = 1'b1;
    end
    xl = translate(u_sel);
    now_b = |(mods_r & MOD_BITS[mod_sel]);
    was_b = |(prior_mods_r & MOD_BITS[mod_sel]);
    if (is_mod) begin
      cand_emit  = now_b != was_b;
      cand_kind  = was_b ? EV_UP : EV_DOWN;
      cand_code  = MOD_CODES[mod_sel];
      cand_ascii = 7'h00;
    end else begin
      cand_emit  = (u_sel > 8'd1) && !found && xl.hit;
      cand_kind  = is_down ? EV_DOWN : EV_UP;
      cand_code  = xl.code;
      cand_ascii = is_down ? xl.ascii : 7'h00;
    end
  end

  logic out_free;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    mods_nxt       = mods_r;
    cur_nxt        = cur_r;
    prior_mods_nxt = prior_mods_r;
    prior_keys_nxt = prior_keys_r;
    pend_valid_nxt = pend_valid_r;
    pend_kind_nxt  = pend_kind_r;
    pend_code_nxt  = pend_code_r;
    pend_ascii_nxt = pend_ascii_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_kind_nxt   = out_kind_r;
    out_code_nxt   = out_code_r;
    out_ascii_nxt  = out_ascii_r;
    out_last_nxt   = out_last_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && (in_report_length >= MIN_REPORT_LEN)) begin
          mods_nxt       = in_modifier_byte;
          cur_nxt        = in_slots;
          idx_nxt        = '0;
          pend_valid_nxt = 1'b0;
          state_nxt      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!(cand_emit && pend_valid_r && !out_free)) begin
          if (cand_emit) begin
            if (pend_valid_r) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = pend_kind_r;
              out_code_nxt  = pend_code_r;
              out_ascii_nxt = pend_ascii_r;
              out_last_nxt  = 1'b0;
            end
            pend_valid_nxt = 1'b1;
            pend_kind_nxt  = cand_kind;
            pend_code_nxt  = cand_code;
            pend_ascii_nxt = cand_ascii;
          end
          idx_nxt = idx_r + 1'b1;
          if (idx_r == CAND_W'(NUM_CAND - 1)) state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!pend_valid_r || out_free) begin
          if (pend_valid_r) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = pend_kind_r;
            out_code_nxt  = pend_code_r;
            out_ascii_nxt = pend_ascii_r;
            out_last_nxt  = 1'b1;
          end
          pend_valid_nxt = 1'b0;
          prior_mods_nxt = mods_r;
          prior_keys_nxt = cur_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      prior_mods_r <= '0;
      prior_keys_r <= '{default: '0};
    end else begin
      state_r      <= state_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      prior_mods_r <= prior_mods_nxt;
      prior_keys_r <= prior_keys_nxt;
      idx_r        <= idx_nxt;
      mods_r       <= mods_nxt;
      cur_r        <= cur_nxt;
      pend_kind_r  <= pend_kind_nxt;
      pend_code_r  <= pend_code_nxt;
      pend_ascii_r <= pend_ascii_nxt;
      out_kind_r   <= out_kind_nxt;
      out_code_r   <= out_code_nxt;
      out_ascii_r  <= out_ascii_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign in_stall       = state_r != ST_IDLE;
  assign out_valid      = out_valid_r;
  assign out_event_kind = out_kind_r;
  assign out_key_code   = out_code_r;
  assign out_ascii_code = out_ascii_r;
  assign out_last       = out_last_r;

endmodule
`default_nettype wire

// ----- test/hid_keyboard_report_to_key_events_test.sv -----
// Self-checking testbench for the boot keyboard report to key event decoder.
`timescale 1ns / 100ps
module hid_keyboard_report_to_key_events_test;
  import hidkbd_pkg::*;

  // Run shape
  localparam int STALL_LIMIT    = 4000;  // cycles with no transaction on either side
  localparam int TAIL_CYCLES    = 40;    // idle tail after the last expected event
  localparam int LONG_HOLD      = 200;   // receiver hold-off for the back-pressure test
  localparam int RANDOM_REPORTS = 75;    // full-length random reports
  localparam int MAX_IDLE       = 16;

  localparam logic [6:0] MAX_REPORT_LEN = 7'd64;

  // HID usages the decoder knows about
  localparam logic [7:0] U_A         = 8'h04;
  localparam logic [7:0] U_Z         = 8'h1D;
  localparam logic [7:0] U_1         = 8'h1E;
  localparam logic [7:0] U_9         = 8'h26;
  localparam logic [7:0] U_0         = 8'h27;
  localparam logic [7:0] U_ENTER     = 8'h28;
  localparam logic [7:0] U_ESCAPE    = 8'h29;
  localparam logic [7:0] U_BACKSPACE = 8'h2A;
  localparam logic [7:0] U_TAB       = 8'h2B;
  localparam logic [7:0] U_SPACE     = 8'h2C;
  localparam logic [7:0] U_UNKNOWN   = 8'h2D;  // minus: not in the table
  localparam logic [7:0] U_COMMA     = 8'h36;
  localparam logic [7:0] U_PERIOD    = 8'h37;
  localparam logic [7:0] U_F1        = 8'h3A;
  localparam logic [7:0] U_F10       = 8'h43;
  localparam logic [7:0] U_F11       = 8'h44;
  localparam logic [7:0] U_F12       = 8'h45;
  localparam logic [7:0] U_RIGHT     = 8'h4F;
  localparam logic [7:0] U_LEFT      = 8'h50;
  localparam logic [7:0] U_DOWN      = 8'h51;
  localparam logic [7:0] U_UP        = 8'h52;
  localparam logic [7:0] U_ROLLOVER  = 8'h01;  // usages 0 and 1 never make events

  // Game key codes
  localparam logic [7:0] KC_TAB       = 8'd9;
  localparam logic [7:0] KC_ENTER     = 8'd13;
  localparam logic [7:0] KC_ESCAPE    = 8'd27;
  localparam logic [7:0] KC_BACKSPACE = 8'h7F;
  localparam logic [7:0] KC_RCTRL     = 8'h9D;
  localparam logic [7:0] KC_RSHIFT    = 8'hB6;
  localparam logic [7:0] KC_RALT      = 8'hB8;
  localparam logic [7:0] KC_LEFT      = 8'hAC;
  localparam logic [7:0] KC_UP        = 8'hAD;
  localparam logic [7:0] KC_RIGHT     = 8'hAE;
  localparam logic [7:0] KC_DOWN      = 8'hAF;
  localparam logic [7:0] KC_F1        = 8'hBB;
  localparam logic [7:0] KC_F11       = 8'hD7;
  localparam logic [7:0] KC_F12       = 8'hD8;

  typedef struct packed {
    logic       kind;
    logic [7:0] code;
    logic [6:0] ascii;
    logic       last;
  } key_event_t;

  typedef logic [7:0] slot_set_t [KEY_SLOTS];

  // DUT ports; inputs driven to known values from time zero
  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [6:0] in_report_length = '0;
  logic [7:0] in_modifier_byte = '0;
  logic [7:0] in_key_slot_0 = '0;
  logic [7:0] in_key_slot_1 = '0;
  logic [7:0] in_key_slot_2 = '0;
  logic [7:0] in_key_slot_3 = '0;
  logic [7:0] in_key_slot_4 = '0;
  logic [7:0] in_key_slot_5 = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_event_kind;
  logic [7:0] out_key_code;
  logic [6:0] out_ascii_code;
  logic       out_last;

  // Decoder state as the testbench sees it: previous modifiers and slots
  logic [7:0] held_mods = 8'h00;
  slot_set_t  held_keys = '{default: 8'h00};

  // Key events still owed by the DUT, oldest first
  key_event_t owed_events [$];

  int   fail_count = 0;
  int   quiet_cycles = 0;
  int   sender_max_gap = MAX_IDLE;
  int   next_gap = 0;
  bit   valid_left_high = 1'b0;
  int   rx_max_wait = MAX_IDLE;
  int   rx_wait = 0;
  logic hold_long = 1'b0;

  hid_keyboard_report_to_key_events dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_report_length (in_report_length),
    .in_modifier_byte (in_modifier_byte),
    .in_key_slot_0    (in_key_slot_0),
    .in_key_slot_1    (in_key_slot_1),
    .in_key_slot_2    (in_key_slot_2),
    .in_key_slot_3    (in_key_slot_3),
    .in_key_slot_4    (in_key_slot_4),
    .in_key_slot_5    (in_key_slot_5),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_kind   (out_event_kind),
    .out_key_code     (out_key_code),
    .out_ascii_code   (out_ascii_code),
    .out_last         (out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Usage to game key code; ascii is the printable character or zero.
  function automatic bit lookup_usage(input logic [7:0] u, output logic [7:0] code,
                                      output logic [6:0] ascii);
    code = 8'h00;
    ascii = 7'h00;
    if (u >= U_A && u <= U_Z) begin
      code = "a" + (u - U_A);
      ascii = code[6:0];
    end else if (u >= U_1 && u <= U_9) begin
      code = "1" + (u - U_1);
      ascii = code[6:0];
    end else if (u == U_0) begin
      code = "0";
      ascii = code[6:0];
    end else if (u >= U_F1 && u <= U_F10) begin
      code = KC_F1 + (u - U_F1);
    end else begin
      case (u)
        U_ENTER:     code = KC_ENTER;
        U_ESCAPE:    code = KC_ESCAPE;
        U_BACKSPACE: code = KC_BACKSPACE;
        U_TAB:       code = KC_TAB;
        U_SPACE: begin
          code = " ";
          ascii = code[6:0];
        end
        U_COMMA: begin
          code = ",";
          ascii = code[6:0];
        end
        U_PERIOD: begin
          code = ".";
          ascii = code[6:0];
        end
        U_RIGHT:     code = KC_RIGHT;
        U_LEFT:      code = KC_LEFT;
        U_DOWN:      code = KC_DOWN;
        U_UP:        code = KC_UP;
        U_F11:       code = KC_F11;
        U_F12:       code = KC_F12;
        default:     return 1'b0;
      endcase
    end
    return 1'b1;
  endfunction

  function automatic bit slot_holds(input slot_set_t slots, input logic [7:0] u);
    foreach (slots[j]) begin
      if (slots[j] == u) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Work out the events one accepted report causes and advance the held state.
  function automatic void predict_report(input logic [6:0] len, input logic [7:0] mods,
                                         input slot_set_t keys);
    key_event_t found [$];
    logic [7:0] mask;
    logic [7:0] mod_code;
    logic [7:0] code;
    logic [6:0] ascii;
    if (len < MIN_REPORT_LEN) return;  // short report: dropped, state kept

    // Modifier edges; bits 0x08 and 0x80 are skipped but still stored
    for (int i = 0; i < 6; i++) begin
      mask = 8'h01 << ((i < 3) ? i : i + 1);
      case (i % 3)
        0:       mod_code = KC_RCTRL;
        1:       mod_code = KC_RSHIFT;
        default: mod_code = KC_RALT;
      endcase
      if ((mods & mask) != 0 && (held_mods & mask) == 0)
        found.push_back('{EV_DOWN, mod_code, 7'h00, 1'b0});
      else if ((mods & mask) == 0 && (held_mods & mask) != 0)
        found.push_back('{EV_UP, mod_code, 7'h00, 1'b0});
    end
    held_mods = mods;

    // Presses in slot order, then releases in previous-slot order
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (keys[i] > U_ROLLOVER && !slot_holds(held_keys, keys[i]) &&
          lookup_usage(keys[i], code, ascii))
        found.push_back('{EV_DOWN, code, ascii, 1'b0});
    end
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (held_keys[i] > U_ROLLOVER && !slot_holds(keys, held_keys[i]) &&
          lookup_usage(held_keys[i], code, ascii))
        found.push_back('{EV_UP, code, 7'h00, 1'b0});
    end
    held_keys = keys;

    if (found.size() > 0) found[found.size() - 1].last = 1'b1;
    foreach (found[i]) owed_events.push_back(found[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Present one report and hold it until it is taken. Valid is left high only
  // when the next report follows with no gap, so nothing is taken twice.
  task automatic send_report(input logic [6:0] len, input logic [7:0] mods,
                             input slot_set_t keys);
    repeat (next_gap) @(posedge clk);
    in_valid         <= 1'b1;
    in_report_length <= len;
    in_modifier_byte <= mods;
    in_key_slot_0    <= keys[0];
    in_key_slot_1    <= keys[1];
    in_key_slot_2    <= keys[2];
    in_key_slot_3    <= keys[3];
    in_key_slot_4    <= keys[4];
    in_key_slot_5    <= keys[5];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_report(len, mods, keys);
    next_gap = $urandom_range(0, sender_max_gap);
    if (next_gap > 0) begin
      in_valid <= 1'b0;
      valid_left_high = 1'b0;
    end else begin
      valid_left_high = 1'b1;
    end
  endtask

  // Sender pause: drop valid and let every owed event arrive.
  task automatic wait_for_events;
    if (valid_left_high) begin
      in_valid <= 1'b0;
      valid_left_high = 1'b0;
      @(posedge clk);
    end
    while (owed_events.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_usage();
    case ($urandom_range(0, 9))
      0, 1, 2: return 8'($urandom_range(U_A, U_0));
      3:       return 8'($urandom_range(U_ENTER, U_SPACE));
      4:       return 8'($urandom_range(U_F1, U_F12));
      5:       return 8'($urandom_range(U_RIGHT, U_UP));
      6:       return ($urandom_range(0, 1) != 0) ? U_COMMA : U_PERIOD;
      7:       return 8'($urandom_range(0, 1));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly a plausible next report: a few slots change, modifiers toggle.
  // One in ten is short, one in ten is pure noise.
  task automatic make_random_report(output logic [6:0] len, output logic [7:0] mods,
                                    output slot_set_t keys);
    int mode;
    mode = $urandom_range(0, 9);
    keys = held_keys;
    mods = held_mods;
    if (mode == 0) len = 7'($urandom_range(0, 7));
    else len = 7'($urandom_range(MIN_REPORT_LEN, MAX_REPORT_LEN));
    if (mode == 1) begin
      foreach (keys[i]) keys[i] = 8'($urandom_range(0, 255));
      mods = 8'($urandom_range(0, 255));
    end else begin
      foreach (keys[i]) begin
        if ($urandom_range(0, 2) == 0) keys[i] = pick_usage();
      end
      if ($urandom_range(0, 1) != 0) mods = held_mods ^ 8'($urandom_range(0, 255));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: random stall after each event, plus the long hold-off
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : receive_side
    int next_wait;
    key_event_t want;
    next_wait = rx_wait;
    if (rst_n && out_valid && !out_stall) begin
      next_wait = $urandom_range(0, rx_max_wait);
      if (owed_events.size() == 0) begin
        $error("unexpected event: kind %0d, key_code %h, ascii_code %h, last %0d",
               out_event_kind, out_key_code, out_ascii_code, out_last);
        fail_count++;
      end else begin
        want = owed_events.pop_front();
        if (out_event_kind !== want.kind) begin
          $error("event_kind: expected %0d, actual %0d", want.kind, out_event_kind);
          fail_count++;
        end
        if (out_key_code !== want.code) begin
          $error("key_code: expected %h, actual %h", want.code, out_key_code);
          fail_count++;
        end
        if (out_ascii_code !== want.ascii) begin
          $error("ascii_code: expected %h, actual %h", want.ascii, out_ascii_code);
          fail_count++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, out_last);
          fail_count++;
        end
      end
    end else if (rx_wait > 0) begin
      next_wait = rx_wait - 1;
    end
    rx_wait   <= next_wait;
    out_stall <= hold_long || (next_wait > 0);
  end

  // Watchdog: too long without a transaction on either channel ends the run.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Lengths below eight are taken and dropped; state must not move.
  task automatic test_short_reports;
    slot_set_t k;
    k = '{U_A, U_ENTER, U_F1, U_SPACE, U_Z, U_0};
    send_report(7'd0, 8'hFF, k);
    send_report(MIN_REPORT_LEN - 7'd1, 8'hFF, k);
    wait_for_events;
  endtask

  // All modifier bits, the two unknown bits alone, then left/right pairs.
  task automatic test_modifiers;
    slot_set_t k;
    k = '{default: 8'h00};
    send_report(MIN_REPORT_LEN, 8'hFF, k);
    send_report(MIN_REPORT_LEN, 8'h88, k);
    send_report(MIN_REPORT_LEN, 8'h00, k);
    send_report(MIN_REPORT_LEN, 8'h11, k);
    send_report(MIN_REPORT_LEN, 8'h66, k);
    send_report(MIN_REPORT_LEN, 8'h00, k);
    wait_for_events;
  endtask

  // Every table region, range edges, unknown usages and usages 0 and 1.
  task automatic test_translation;
    slot_set_t k;
    k = '{U_A, U_Z, U_1, U_9, U_0, U_ENTER};
    send_report(MIN_REPORT_LEN, 8'h00, k);
    k = '{U_ESCAPE, U_BACKSPACE, U_TAB, U_SPACE, U_COMMA, U_PERIOD};
    send_report(MIN_REPORT_LEN, 8'h00, k);
    k = '{U_F1, U_F10, U_F11, U_F12, U_RIGHT, U_LEFT};
    send_report(MIN_REPORT_LEN, 8'h00, k);
    k = '{U_DOWN, U_UP, 8'h00, U_ROLLOVER, 8'hFF, U_UNKNOWN};
    send_report(MIN_REPORT_LEN, 8'h00, k);
    k = '{default: 8'h00};
    send_report(MIN_REPORT_LEN, 8'h00, k);
    wait_for_events;
  endtask

  // Six modifier edges, six presses and six releases from one report.
  task automatic test_full_turnover;
    slot_set_t k;
    k = '{U_A, U_A + 8'd1, U_A + 8'd2, U_A + 8'd3, U_A + 8'd4, U_A + 8'd5};
    send_report(MAX_REPORT_LEN, 8'h77, k);
    k = '{U_A + 8'd6, U_A + 8'd7, U_A + 8'd8, U_A + 8'd9, U_A + 8'd10, U_A + 8'd11};
    send_report(MAX_REPORT_LEN, 8'h00, k);
    wait_for_events;
  endtask

  // Same usage in two slots: two presses, later two releases.
  task automatic test_repeated_usage;
    slot_set_t k;
    k = '{U_A, U_A, U_SPACE, U_SPACE, 8'h00, 8'h00};
    send_report(MIN_REPORT_LEN, 8'h00, k);
    k = '{U_UNKNOWN, U_UNKNOWN, 8'h00, 8'h00, 8'h00, 8'h00};
    send_report(MIN_REPORT_LEN, 8'h00, k);
    wait_for_events;
  endtask

  // A repeated report changes nothing and gives no events.
  task automatic test_no_change;
    slot_set_t k;
    k = '{U_DOWN, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    send_report(MAX_REPORT_LEN, 8'h02, k);
    send_report(MAX_REPORT_LEN, 8'h02, k);
    wait_for_events;
  endtask

  // Receiver holds off while the sender keeps offering back-to-back reports,
  // so the output fills and the input stalls.
  task automatic test_back_pressure;
    logic [6:0] len;
    logic [7:0] mods;
    slot_set_t  k;
    wait_for_events;
    @(posedge clk);
    hold_long <= 1'b1;
    fork
      begin
        repeat (LONG_HOLD) @(posedge clk);
        hold_long <= 1'b0;
      end
    join_none
    sender_max_gap = 0;
    next_gap = 0;
    repeat (8) begin
      make_random_report(len, mods, k);
      len = MAX_REPORT_LEN;
      send_report(len, mods, k);
    end
    sender_max_gap = MAX_IDLE;
    wait_for_events;
  endtask

  // Random reports; a stretch in the middle runs with no idling on either side.
  task automatic test_random_reports;
    logic [6:0] len;
    logic [7:0] mods;
    slot_set_t  k;
    int         full_reports;
    full_reports = 0;
    while (full_reports < RANDOM_REPORTS) begin
      if (full_reports == 40) begin
        sender_max_gap = 0;
        rx_max_wait <= 0;
      end else if (full_reports == 60) begin
        sender_max_gap = MAX_IDLE;
        rx_max_wait <= MAX_IDLE;
      end
      make_random_report(len, mods, k);
      send_report(len, mods, k);
      if (len >= MIN_REPORT_LEN) full_reports++;
    end
    wait_for_events;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_short_reports;
    test_modifiers;
    test_translation;
    test_full_turnover;
    test_repeated_usage;
    test_no_change;
    test_back_pressure;
    test_random_reports;

    // Catch any stray events after the last expected one
    wait_for_events;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
